// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define XSG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define XSG_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define XSG_ASSERT(lbl, clk, rst_n, prop, msg)
`define XSG_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ----- hw/rtl/xsg_pkg.sv -----
// Shared constants and codes of the xorshift1024* gaussian generator.
package xsg_pkg;
    localparam int STATE_WORDS = 16;
    localparam int PTR_W = $clog2(STATE_WORDS);
    localparam int DEVIATE_FRACTION_BITS = 27;
    localparam int TRY_LIMIT = 64;
    localparam int TRY_W = $clog2(TRY_LIMIT);
    localparam logic [31:0] SCR_LO = 32'h5497FDB5;
    localparam logic [31:0] SCR_HI = 32'h106689D4;
    localparam logic [31:0] LN2_Q28 = 32'h0B17217F;
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_UNIFORM = 2'd1;
    localparam logic [1:0] OP_GAUSS = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;
endpackage

// ----- hw/rtl/xsg_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module xsg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = xsg_pkg::STATE_WORDS
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hw/rtl/xorshift1024_star_gaussian_rng.sv -----
// xorshift1024* generator with a fixed-point polar-method gaussian stage.
// Uniform beat: two ring reads, update, three 32x32 partial products.
// Gaussian beat with a held spare: sent from the spare. New pair: tries of two draws; an accepted try
// adds normalise, log, scale and, for each of two deviates, divide, root and finish.
// One shared 32x32 multiplier and 64-bit subtractor; up to 64 tries, with s_tready low while busy.
// Synchronous active-low reset clears the ring (valid bits), pointer, spare and m_tvalid.
`include "assert_macros.svh"
module xorshift1024_star_gaussian_rng #(
    parameter int DEVIATE_FRACTION_BITS = xsg_pkg::DEVIATE_FRACTION_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // word_index[3:0], word_value[67:4], zero pad
    input  logic [1:0]  s_tuser,  // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,  // uniform_fraction[63:0], gaussian_value[95:64]
    output logic [0:0]  m_tuser   // is_gaussian[0]
);
    localparam int SH = 56 - 2 * DEVIATE_FRACTION_BITS;
    localparam int PW = xsg_pkg::PTR_W;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RD0, ST_RD1, ST_CALC, ST_MUL0, ST_MUL1, ST_MUL2,
        ST_SQ1, ST_SQ2, ST_CHECK, ST_NORM, ST_LOG, ST_LN0, ST_LN1,
        ST_DIV, ST_CMUL, ST_SQRT, ST_FINISH, ST_EMIT
    } state_t;

    state_t state_reg;
    logic [PW-1:0] ptr_reg;
    logic [xsg_pkg::STATE_WORDS-1:0] ring_valid_reg;
    logic rd_valid_reg;
    logic spare_valid_reg;
    logic [31:0] spare_reg;
    logic is_gauss_op_reg;
    logic draw_idx_reg;
    logic phase_reg;
    logic [xsg_pkg::TRY_W-1:0] tries_reg;
    logic [63:0] s0_reg, w_reg, acc_reg;
    logic [31:0] a1_reg, a2_reg;
    logic neg1_reg, neg2_reg, neg_cur_reg;
    logic [63:0] q1_reg, q2_reg, sv_reg;
    logic [61:0] nw_reg;
    logic [5:0] k_reg, cnt_reg;
    logic [31:0] m_reg;
    logic [29:0] frac_reg;
    logic [30:0] l_reg;
    logic [63:0] r_reg;
    logic [32:0] c_reg;
    logic [63:0] v_reg, res_reg, bit_reg;
    logic [63:0] uni_res_reg;
    logic [31:0] gau_res_reg;
    logic isg_res_reg;
    logic m_tvalid_reg;
    logic [95:0] m_tdata_reg;
    logic m_tuser_reg;

    logic ram_we;
    logic [PW-1:0] ram_waddr, ram_raddr;
    logic [63:0] ram_wdata, ram_rdata, rd_word;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [63:0] sub_a, sub_b;
    logic [64:0] sub_out;
    logic [63:0] s1x, new_word, scr_sum;
    logic [31:0] u_top, u_abs;
    logic [32:0] sq_t;
    logic [35:0] n_val;
    logic [63:0] ln_sum;
    logic [31:0] mag_sat, dev;
    logic in_beat;

    assign in_beat = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

    xsg_ram #(.WIDTH(64), .DEPTH(xsg_pkg::STATE_WORDS)) u_ring (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_word = rd_valid_reg ? ram_rdata : 64'd0;
    assign ram_raddr = (state_reg == ST_RD1) ? PW'(ptr_reg + 1'b1) : ptr_reg;

    // ring update: rd_word holds s1 in the update cycle
    assign s1x = rd_word ^ {rd_word[32:0], 31'd0};
    assign new_word = s1x ^ s0_reg ^ {11'd0, s1x[63:11]} ^ {30'd0, s0_reg[63:30]};

    always_comb begin
        ram_we = 1'b0;
        ram_waddr = PW'(ptr_reg + 1'b1);
        ram_wdata = new_word;
        if (state_reg == ST_IDLE && in_beat && s_tuser == xsg_pkg::OP_LOAD) begin
            ram_we = 1'b1;
            ram_waddr = s_tdata[3:0];
            ram_wdata = s_tdata[67:4];
        end else if (state_reg == ST_CALC) begin
            ram_we = 1'b1;
        end
    end

    // shared multiplier operand select
    always_comb begin
        case (state_reg)
            ST_MUL0: begin mul_a = w_reg[31:0];  mul_b = xsg_pkg::SCR_LO; end
            ST_MUL1: begin mul_a = w_reg[63:32]; mul_b = xsg_pkg::SCR_LO; end
            ST_MUL2: begin mul_a = w_reg[31:0];  mul_b = xsg_pkg::SCR_HI; end
            ST_SQ1:  begin mul_a = a1_reg;       mul_b = a1_reg; end
            ST_SQ2:  begin mul_a = a2_reg;       mul_b = a2_reg; end
            ST_LOG:  begin mul_a = m_reg;        mul_b = m_reg; end
            ST_LN0:  begin mul_a = n_val[31:0];  mul_b = xsg_pkg::LN2_Q28; end
            ST_LN1:  begin mul_a = {28'd0, n_val[35:32]}; mul_b = xsg_pkg::LN2_Q28; end
            ST_CMUL: begin mul_a = c_reg[31:0];  mul_b = {1'b0, l_reg}; end
            default: begin mul_a = 32'd0;        mul_b = 32'd0; end
        endcase
    end
    assign prod = 64'(mul_a) * 64'(mul_b);

    // shared subtractor: restoring divide and square root
    always_comb begin
        case (state_reg)
            ST_DIV: begin
                sub_a = (cnt_reg == 6'd0) ? r_reg : {r_reg[62:0], 1'b0};
                sub_b = sv_reg;
            end
            ST_SQRT: begin
                sub_a = v_reg;
                sub_b = res_reg + bit_reg;
            end
            default: begin
                sub_a = 64'd0;
                sub_b = 64'd0;
            end
        endcase
    end
    assign sub_out = {1'b0, sub_a} - {1'b0, sub_b};

    assign scr_sum = acc_reg + {prod[31:0], 32'd0};
    assign u_top = scr_sum[63:32];
    assign u_abs = u_top[31] ? {1'b0, u_top[30:0]} : (32'h80000000 - u_top);
    assign sq_t = prod[63:31];
    assign n_val = {6'(k_reg + 6'd1), 30'd0} - {6'd0, frac_reg};
    assign ln_sum = acc_reg + {prod[31:0], 32'd0};

    always_comb begin
        if (neg_cur_reg) begin
            mag_sat = (res_reg > 64'h80000000) ? 32'h80000000 : res_reg[31:0];
            dev = 32'd0 - mag_sat;
        end else begin
            mag_sat = (res_reg > 64'h7FFFFFFF) ? 32'h7FFFFFFF : res_reg[31:0];
            dev = mag_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ptr_reg <= '0;
            ring_valid_reg <= '0;
            rd_valid_reg <= 1'b0;
            spare_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= ring_valid_reg[ram_raddr];
            if (ram_we) begin
                ring_valid_reg[ram_waddr] <= 1'b1;
            end
            if (m_tready && state_reg != ST_EMIT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_beat) begin
                        case (s_tuser)
                            xsg_pkg::OP_LOAD: begin
                                ptr_reg <= '0;
                                spare_valid_reg <= 1'b0;
                            end
                            xsg_pkg::OP_UNIFORM: begin
                                is_gauss_op_reg <= 1'b0;
                                state_reg <= ST_RD0;
                            end
                            xsg_pkg::OP_GAUSS: begin
                                is_gauss_op_reg <= 1'b1;
                                if (spare_valid_reg) begin
                                    spare_valid_reg <= 1'b0;
                                    uni_res_reg <= 64'd0;
                                    gau_res_reg <= spare_reg;
                                    isg_res_reg <= 1'b1;
                                    state_reg <= ST_EMIT;
                                end else begin
                                    tries_reg <= '0;
                                    draw_idx_reg <= 1'b0;
                                    state_reg <= ST_RD0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_RD0: state_reg <= ST_RD1;
                ST_RD1: begin
                    s0_reg <= rd_word;
                    state_reg <= ST_CALC;
                end
                ST_CALC: begin
                    w_reg <= new_word;
                    ptr_reg <= PW'(ptr_reg + 1'b1);
                    state_reg <= ST_MUL0;
                end
                ST_MUL0: begin
                    acc_reg <= prod;
                    state_reg <= ST_MUL1;
                end
                ST_MUL1: begin
                    acc_reg <= scr_sum;
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    if (!is_gauss_op_reg) begin
                        uni_res_reg <= scr_sum;
                        gau_res_reg <= 32'd0;
                        isg_res_reg <= 1'b0;
                        state_reg <= ST_EMIT;
                    end else if (!draw_idx_reg) begin
                        a1_reg <= u_abs;
                        neg1_reg <= ~u_top[31];
                        draw_idx_reg <= 1'b1;
                        state_reg <= ST_RD0;
                    end else begin
                        a2_reg <= u_abs;
                        neg2_reg <= ~u_top[31];
                        state_reg <= ST_SQ1;
                    end
                end
                ST_SQ1: begin
                    q1_reg <= prod;
                    state_reg <= ST_SQ2;
                end
                ST_SQ2: begin
                    q2_reg <= prod;
                    sv_reg <= q1_reg + prod;
                    state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (sv_reg == 64'd0 || sv_reg[63:62] != 2'd0) begin
                        if (tries_reg == xsg_pkg::TRY_W'(xsg_pkg::TRY_LIMIT - 1)) begin
                            uni_res_reg <= 64'd0;
                            gau_res_reg <= 32'd0;
                            isg_res_reg <= 1'b1;
                            state_reg <= ST_EMIT;
                        end else begin
                            tries_reg <= tries_reg + 1'b1;
                            draw_idx_reg <= 1'b0;
                            state_reg <= ST_RD0;
                        end
                    end else begin
                        nw_reg <= sv_reg[61:0];
                        k_reg <= 6'd0;
                        state_reg <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    // one bit a cycle until the leading one sits at bit 61
                    if (nw_reg[61]) begin
                        m_reg <= nw_reg[61:30];
                        frac_reg <= 30'd0;
                        cnt_reg <= 6'd0;
                        state_reg <= ST_LOG;
                    end else begin
                        nw_reg <= {nw_reg[60:0], 1'b0};
                        k_reg <= k_reg + 6'd1;
                    end
                end
                ST_LOG: begin
                    if (sq_t[32]) begin
                        m_reg <= sq_t[32:1];
                        frac_reg <= {frac_reg[28:0], 1'b1};
                    end else begin
                        m_reg <= sq_t[31:0];
                        frac_reg <= {frac_reg[28:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd29) begin
                        state_reg <= ST_LN0;
                    end
                end
                ST_LN0: begin
                    acc_reg <= prod;
                    state_reg <= ST_LN1;
                end
                ST_LN1: begin
                    l_reg <= ln_sum[63:33];
                    r_reg <= q2_reg;
                    neg_cur_reg <= neg2_reg;
                    phase_reg <= 1'b1;
                    cnt_reg <= 6'd0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    r_reg <= sub_out[64] ? sub_a : sub_out[63:0];
                    c_reg <= {c_reg[31:0], ~sub_out[64]};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd32) begin
                        state_reg <= ST_CMUL;
                    end
                end
                ST_CMUL: begin
                    v_reg <= (prod + (c_reg[32] ? {1'b0, l_reg, 32'd0} : 64'd0)) >> SH;
                    res_reg <= 64'd0;
                    bit_reg <= 64'h4000000000000000;
                    cnt_reg <= 6'd0;
                    state_reg <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (!sub_out[64]) begin
                        v_reg <= sub_out[63:0];
                        res_reg <= {1'b0, res_reg[63:1]} + bit_reg;
                    end else begin
                        res_reg <= {1'b0, res_reg[63:1]};
                    end
                    bit_reg <= {2'd0, bit_reg[63:2]};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd31) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (phase_reg) begin
                        spare_reg <= dev;
                        spare_valid_reg <= 1'b1;
                        r_reg <= q1_reg;
                        neg_cur_reg <= neg1_reg;
                        phase_reg <= 1'b0;
                        cnt_reg <= 6'd0;
                        state_reg <= ST_DIV;
                    end else begin
                        uni_res_reg <= 64'd0;
                        gau_res_reg <= dev;
                        isg_res_reg <= 1'b1;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg <= {gau_res_reg, uni_res_reg};
                        m_tuser_reg <= isg_res_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `XSG_ASSERT(a_uni_no_gauss, aclk, aresetn, (m_tvalid && !m_tuser[0]) |-> (m_tdata[95:64] == 32'd0), "uniform beat carries a deviate")
    `XSG_ASSERT(a_gauss_no_uni, aclk, aresetn, (m_tvalid && m_tuser[0]) |-> (m_tdata[63:0] == 64'd0), "gaussian beat carries a uniform word")
    `XSG_ASSERT(a_load_clears, aclk, aresetn, (in_beat && s_tuser == xsg_pkg::OP_LOAD) |=> (ptr_reg == '0 && !spare_valid_reg), "load left pointer or spare")
    `XSG_NEVER(a_ring_write_busy, aclk, aresetn, ram_we && state_reg != ST_IDLE && state_reg != ST_CALC, "ring written outside load or update")
endmodule
